FILE: rtl/daa_pkg.sv
// Shared widths, constants and register indexes for the driver-assist alarm unit.
`timescale 1ns / 1ps

package daa_pkg;

    localparam int DIST_W = 9;
    localparam int SPD_W  = 12;
    localparam int TTC_W  = 14;
    localparam int HOLD_W = 8;
    localparam int LVL_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // front < 200 keeps front*36 below 7200, so 13 bits carry the dividend
    localparam int NUM_W = 13;
    localparam int CNT_W = $clog2(NUM_W);

    localparam logic [TTC_W-1:0]  TTC_SAFE  = TTC_W'(9990);
    localparam logic [SPD_W-1:0]  MIN_SPEED = SPD_W'(18);
    localparam logic [DIST_W-1:0] MAX_FRONT = DIST_W'(200);

    localparam logic [LVL_W-1:0] LVL_NONE = 2'd0;
    localparam logic [LVL_W-1:0] LVL_WARN = 2'd1;
    localparam logic [LVL_W-1:0] LVL_CRIT = 2'd2;

    localparam logic [1:0] PRIO_NONE     = 2'd0;
    localparam logic [1:0] PRIO_ADVISORY = 2'd1;
    localparam logic [1:0] PRIO_WARNING  = 2'd2;
    localparam logic [1:0] PRIO_CRITICAL = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CRIT_DISTANCE = 3'd0,
        REG_WARN_DISTANCE = 3'd1,
        REG_CRIT_TIME     = 3'd2,
        REG_WARN_TIME     = 3'd3,
        REG_SIDE_DISTANCE = 3'd4,
        REG_SIDE_SPEED    = 3'd5,
        REG_SPEED_LIMIT   = 3'd6,
        REG_HOLD_COUNT    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: rtl/daa_div.sv
// Restoring divider, one quotient bit per cycle through one shared subtractor.
`timescale 1ns / 1ps

module daa_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [daa_pkg::NUM_W-1:0]  numer,
    input  logic [daa_pkg::SPD_W-1:0]  denom,
    output logic [daa_pkg::NUM_W-1:0]  quot,
    output daa_pkg::div_stat_t         stat
);
    import daa_pkg::*;

    logic [NUM_W-1:0] work_reg, work_next;
    logic [SPD_W-1:0] rem_reg, rem_next;
    logic [SPD_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [SPD_W:0] rem_shift;
    logic [SPD_W:0] diff;
    logic           fits;

    always_comb
    begin
        rem_shift = {rem_reg, work_reg[NUM_W-1]};
        diff      = rem_shift - {1'b0, den_reg};
        fits      = rem_shift >= {1'b0, den_reg};
    end

    always_comb
    begin
        work_next = work_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            work_next = numer;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so its top bit drops safely
            rem_next  = fits ? diff[SPD_W-1:0] : rem_shift[SPD_W-1:0];
            work_next = {work_reg[NUM_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        if (start)
        begin
            den_reg <= denom;
        end
    end

    assign quot      = work_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: rtl/driver_assist_alarm_unit.sv
// Top level of the driver-assist alarm unit: sequencer, alarm holds and result register.
`timescale 1ns / 1ps

// One sensor request is taken when in_ready is high; in_ready then stays low
// until the result has been moved into the output register. When the front
// obstacle is nearer than 2 m and speed exceeds 1.8 km/h, time to collision
// is front*36/speed from a bit-serial divider, one quotient bit a cycle:
// out_valid rises after the divider steps, ST_DIV sees done, and ST_DONE
// registers the result once the output register is free.
// Otherwise the request goes straight to ST_DONE and is registered there.
// A new request may be taken while the previous result waits on out_ready.
// Configuration writes take effect at once and must only be issued while idle.

module driver_assist_alarm_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [daa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [daa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [daa_pkg::DIST_W-1:0]      front_dist,
    input  logic [daa_pkg::DIST_W-1:0]      left_dist,
    input  logic [daa_pkg::DIST_W-1:0]      right_dist,
    input  logic [daa_pkg::SPD_W-1:0]       speed,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [daa_pkg::TTC_W-1:0]       ttc,
    output logic [daa_pkg::LVL_W-1:0]       collision_level,
    output logic                            blind_left,
    output logic                            blind_right,
    output logic                            over_speed,
    output logic [1:0]                      priority_res
);
    import daa_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    // hold counter step: {active, next count}
    function automatic logic [HOLD_W:0] hold_step(input logic [HOLD_W-1:0] h,
                                                  input logic              cond,
                                                  input logic [HOLD_W-1:0] load);
        logic [HOLD_W:0] r;
        if (cond)
            r = {1'b1, load};
        else if (h != '0)
            r = {1'b1, h - 1'b1};
        else
            r = {1'b0, h};
        return r;
    endfunction

    state_t state_reg, state_next;

    // configuration
    logic [DIST_W-1:0] crit_distance_reg, warn_distance_reg, side_distance_reg;
    logic [TTC_W-1:0]  crit_time_reg, warn_time_reg;
    logic [SPD_W-1:0]  side_speed_reg, speed_limit_reg;
    logic [HOLD_W-1:0] hold_count_reg;

    // holds
    logic [HOLD_W-1:0] crit_hold_reg, warn_hold_reg, left_hold_reg;
    logic [HOLD_W-1:0] right_hold_reg, speed_hold_reg;
    logic [HOLD_W-1:0] crit_hold_next, warn_hold_next, left_hold_next;
    logic [HOLD_W-1:0] right_hold_next, speed_hold_next;

    // latched request
    logic [DIST_W-1:0] front_reg, left_reg, right_reg;
    logic [SPD_W-1:0]  speed_reg;
    logic              use_div_reg;

    // result register
    logic              out_valid_reg;
    logic [TTC_W-1:0]  ttc_reg;
    logic [LVL_W-1:0]  level_reg;
    logic              bl_reg, br_reg, ov_reg;
    logic [1:0]        prio_reg;

    logic              in_fire, commit, div_start;
    logic              use_div_in;
    logic [DIST_W+5:0] prod;
    logic [NUM_W-1:0]  quot;
    div_stat_t         div_stat;

    logic [TTC_W-1:0]  ttc_val;
    logic              crit_cond, warn_cond, side_on;
    logic [HOLD_W:0]   crit_s, warn_s, left_s, right_s, speed_s;
    logic [LVL_W-1:0]  level_val;
    logic [1:0]        prio_val;

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign use_div_in = (speed > MIN_SPEED) && (front_dist < MAX_FRONT);
    assign div_start  = in_fire && use_div_in;
    assign commit     = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // front*36 as two shifted terms
    assign prod = {1'b0, front_dist, 5'b0} + {4'b0, front_dist, 2'b0};

    daa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (prod[NUM_W-1:0]),
        .denom (speed),
        .quot  (quot),
        .stat  (div_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = use_div_in ? ST_DIV : ST_DONE;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (commit)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // evaluation; quotient is at most 7199/19, so it never needs limiting
    always_comb
    begin
        ttc_val   = use_div_reg ? TTC_W'(quot) : TTC_SAFE;
        crit_cond = (front_reg < crit_distance_reg) || (ttc_val < crit_time_reg);
        warn_cond = (front_reg < warn_distance_reg) || (ttc_val < warn_time_reg);
        side_on   = speed_reg > side_speed_reg;

        crit_s  = hold_step(crit_hold_reg, crit_cond, hold_count_reg);
        warn_s  = hold_step(warn_hold_reg, warn_cond, hold_count_reg);
        left_s  = hold_step(left_hold_reg, (left_reg < side_distance_reg) && side_on,
                            hold_count_reg);
        right_s = hold_step(right_hold_reg, (right_reg < side_distance_reg) && side_on,
                            hold_count_reg);
        speed_s = hold_step(speed_hold_reg, speed_reg > speed_limit_reg, hold_count_reg);

        crit_hold_next  = crit_s[HOLD_W-1:0];
        left_hold_next  = left_s[HOLD_W-1:0];
        right_hold_next = right_s[HOLD_W-1:0];
        speed_hold_next = speed_s[HOLD_W-1:0];

        // critical clears the warning hold and masks its update
        if (crit_s[HOLD_W])
        begin
            warn_hold_next = '0;
            level_val      = LVL_CRIT;
            prio_val       = PRIO_CRITICAL;
        end
        else if (warn_s[HOLD_W])
        begin
            warn_hold_next = warn_s[HOLD_W-1:0];
            level_val      = LVL_WARN;
            prio_val       = PRIO_WARNING;
        end
        else
        begin
            warn_hold_next = warn_s[HOLD_W-1:0];
            level_val      = LVL_NONE;
            prio_val       = (left_s[HOLD_W] || right_s[HOLD_W] || speed_s[HOLD_W]) ?
                             PRIO_ADVISORY : PRIO_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            out_valid_reg     <= 1'b0;
            crit_distance_reg <= DIST_W'(30);
            warn_distance_reg <= DIST_W'(80);
            crit_time_reg     <= TTC_W'(100);
            warn_time_reg     <= TTC_W'(250);
            side_distance_reg <= DIST_W'(100);
            side_speed_reg    <= SPD_W'(200);
            speed_limit_reg   <= SPD_W'(1200);
            hold_count_reg    <= HOLD_W'(3);
            crit_hold_reg     <= '0;
            warn_hold_reg     <= '0;
            left_hold_reg     <= '0;
            right_hold_reg    <= '0;
            speed_hold_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (commit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (commit)
            begin
                crit_hold_reg  <= crit_hold_next;
                warn_hold_reg  <= warn_hold_next;
                left_hold_reg  <= left_hold_next;
                right_hold_reg <= right_hold_next;
                speed_hold_reg <= speed_hold_next;
            end

            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_CRIT_DISTANCE: crit_distance_reg <= cfg_wdata[DIST_W-1:0];
                    REG_WARN_DISTANCE: warn_distance_reg <= cfg_wdata[DIST_W-1:0];
                    REG_CRIT_TIME:     crit_time_reg     <= cfg_wdata[TTC_W-1:0];
                    REG_WARN_TIME:     warn_time_reg     <= cfg_wdata[TTC_W-1:0];
                    REG_SIDE_DISTANCE: side_distance_reg <= cfg_wdata[DIST_W-1:0];
                    REG_SIDE_SPEED:    side_speed_reg    <= cfg_wdata[SPD_W-1:0];
                    REG_SPEED_LIMIT:   speed_limit_reg   <= cfg_wdata[SPD_W-1:0];
                    REG_HOLD_COUNT:    hold_count_reg    <= cfg_wdata[HOLD_W-1:0];
                    default:           hold_count_reg    <= hold_count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            front_reg   <= front_dist;
            left_reg    <= left_dist;
            right_reg   <= right_dist;
            speed_reg   <= speed;
            use_div_reg <= use_div_in;
        end
        if (commit)
        begin
            ttc_reg   <= ttc_val;
            level_reg <= level_val;
            bl_reg    <= left_s[HOLD_W];
            br_reg    <= right_s[HOLD_W];
            ov_reg    <= speed_s[HOLD_W];
            prio_reg  <= prio_val;
        end
    end

    assign out_valid       = out_valid_reg;
    assign ttc             = ttc_reg;
    assign collision_level = level_reg;
    assign blind_left      = bl_reg;
    assign blind_right     = br_reg;
    assign over_speed      = ov_reg;
    assign priority_res    = prio_reg;

    // divider finishes only while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider done outside divide phase");

    // a request that needs the divider always starts it
    a_div_started: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> div_stat.busy && state_reg == ST_DIV)
        else $error("divider not running after start");

    // level and priority agree on every result
    a_prio_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((collision_level == LVL_CRIT) == (priority_res == PRIO_CRITICAL))
                   && ((collision_level == LVL_WARN) == (priority_res == PRIO_WARNING)))
        else $error("priority disagrees with collision level");

endmodule
